// ===== rtl/core/tpaf_pkg.sv =====
// ----------------------------------------------------------------------------
// tpaf_pkg
// Shared widths, register indexes, beat types and the sample scaling divide
// for the triac phase-angle firing block.
// ----------------------------------------------------------------------------
package tpaf_pkg;

  // ADC resolution; full scale is 2^ADC_BITS - 1 (range 8..16)
  localparam int unsigned ADC_BITS   = 12;
  localparam int unsigned ADC_FULL   = (1 << ADC_BITS) - 1;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned HALF_W     = 14;
  localparam int unsigned PULSE_W    = 12;
  localparam int unsigned OFFS_W     = 12;
  localparam int unsigned DCNT_W     = 15;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 14;

  // saturated sample width: never wider than the field, never wider than ADC
  localparam int unsigned SMP_W  = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam int unsigned PROD_W = SMP_W + HALF_W;
  localparam int unsigned SUM_W  = PROD_W + 1;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_HALF_CYCLE = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_PULSE      = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] CFG_ZC_OFFSET  = CFG_ADDR_W'(2);

  // register reset values
  localparam logic [HALF_W-1:0]  HALF_RST  = HALF_W'(8190);
  localparam logic [PULSE_W-1:0] PULSE_RST = PULSE_W'(300);
  localparam logic [OFFS_W-1:0]  OFFS_RST  = OFFS_W'(400);

  typedef struct packed {
    logic [HALF_W-1:0]  half_cycle;
    logic [PULSE_W-1:0] pulse;
    logic [OFFS_W-1:0]  offset;
  } cfg_t;

  // one tick after scaling, handed to the controller
  typedef struct packed {
    logic              zc;
    logic              sv;
    logic [HALF_W-1:0] delay;
  } tick_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_PULSE
  } ctrl_state_t;

  // floor(p / (2^k - 1)) for p < (2^k - 1) * 2^HALF_W.
  // p = a*2^k + b  ->  q = a + floor((a+b)/M); fold a+b once more, then the
  // remainder is below 2M so a single compare finishes it.
  function automatic logic [HALF_W-1:0] div_full(input logic [PROD_W-1:0] p);
    logic [SUM_W-1:0] mask;
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
    logic [SUM_W-1:0] s;
    logic [SUM_W-1:0] c;
    logic [SUM_W-1:0] d;
    logic [SUM_W-1:0] t;
    logic [SUM_W-1:0] q;
    mask = SUM_W'(ADC_FULL);
    a    = SUM_W'(p) >> ADC_BITS;
    b    = SUM_W'(p) & mask;
    s    = a + b;
    c    = s >> ADC_BITS;
    d    = s & mask;
    t    = c + d;
    q    = a + c + ((t >= mask) ? SUM_W'(1) : SUM_W'(0));
    return q[HALF_W-1:0];
  endfunction

endpackage

// ===== rtl/core/tpaf_scale.sv =====
// ----------------------------------------------------------------------------
// tpaf_scale
// Three-stage pipe: input register, sample * half cycle, divide by ADC
// full scale. Edge and sample flags ride along.
// ----------------------------------------------------------------------------
module tpaf_scale (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [tpaf_pkg::HALF_W-1:0]    half_cycle,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_zero_cross_rise,
  input  logic                           in_sample_valid,
  input  logic [tpaf_pkg::SAMPLE_W-1:0]  in_adc_sample,
  output logic                           t_valid,
  input  logic                           t_stall,
  output tpaf_pkg::tick_t                t_beat
);

  logic                          v1_r, v2_r, v3_r;
  logic                          zc1_r, sv1_r, zc2_r, sv2_r;
  logic [tpaf_pkg::SMP_W-1:0]    smp1_r;
  logic [tpaf_pkg::PROD_W-1:0]   prod2_r;
  tpaf_pkg::tick_t               beat3_r;
  logic [tpaf_pkg::SMP_W-1:0]    smp_sat;
  logic                          adv1, adv2, adv3;

  // a stage moves when it is empty or its successor moves
  assign adv3     = !v3_r || !t_stall;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  // clamp to full scale (only bites when ADC_BITS < field width)
  assign smp_sat = (32'(in_adc_sample) > 32'(tpaf_pkg::ADC_FULL)) ?
                   tpaf_pkg::SMP_W'(tpaf_pkg::ADC_FULL) :
                   tpaf_pkg::SMP_W'(in_adc_sample);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      zc1_r  <= in_zero_cross_rise;
      sv1_r  <= in_sample_valid;
      smp1_r <= smp_sat;
    end
    if (adv2) begin
      zc2_r   <= zc1_r;
      sv2_r   <= sv1_r;
      prod2_r <= tpaf_pkg::PROD_W'(smp1_r) * tpaf_pkg::PROD_W'(half_cycle);
    end
    if (adv3) begin
      beat3_r.zc    <= zc2_r;
      beat3_r.sv    <= sv2_r;
      beat3_r.delay <= tpaf_pkg::div_full(prod2_r);
    end
  end

  assign t_valid = v3_r;
  assign t_beat  = beat3_r;

endmodule

// ===== rtl/core/tpaf_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpaf_ctrl
// Firing sequencer: idle / delay countdown / gate pulse, plus the result
// register.
// ----------------------------------------------------------------------------
module tpaf_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tpaf_pkg::cfg_t               cfg,
  input  logic                         t_valid,
  output logic                         t_stall,
  input  tpaf_pkg::tick_t              t_beat,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_gate_drive,
  output logic                         out_busy_res,
  output logic [tpaf_pkg::HALF_W-1:0]  out_delay_setting
);

  tpaf_pkg::ctrl_state_t          state_r, state_nxt;
  logic [tpaf_pkg::DCNT_W-1:0]    dcnt_r, dcnt_nxt;
  logic [tpaf_pkg::PULSE_W-1:0]   pcnt_r, pcnt_nxt;
  logic [tpaf_pkg::HALF_W-1:0]    phase_r, phase_nxt;
  logic                           gate_nxt;
  logic                           out_valid_r, out_gate_r, out_busy_r;
  logic [tpaf_pkg::HALF_W-1:0]    out_delay_r;
  logic                           take;

  assign t_stall   = out_valid_r && out_stall;
  assign take      = t_valid && !t_stall;
  // new sample lands before the edge looks at it
  assign phase_nxt = t_beat.sv ? t_beat.delay : phase_r;

  always_comb begin
    state_nxt = state_r;
    dcnt_nxt  = dcnt_r;
    pcnt_nxt  = pcnt_r;
    unique case (state_r)
      tpaf_pkg::ST_IDLE: begin
        if (t_beat.zc) begin
          state_nxt = tpaf_pkg::ST_WAIT;
          dcnt_nxt  = tpaf_pkg::DCNT_W'(phase_nxt) + tpaf_pkg::DCNT_W'(cfg.offset);
        end
      end
      tpaf_pkg::ST_WAIT: begin
        if (dcnt_r == '0) begin
          if (cfg.pulse == '0) begin
            state_nxt = tpaf_pkg::ST_IDLE;
          end else begin
            state_nxt = tpaf_pkg::ST_PULSE;
            pcnt_nxt  = cfg.pulse - tpaf_pkg::PULSE_W'(1);
          end
        end else begin
          dcnt_nxt = dcnt_r - tpaf_pkg::DCNT_W'(1);
        end
      end
      tpaf_pkg::ST_PULSE: begin
        if (pcnt_r == '0) begin
          state_nxt = tpaf_pkg::ST_IDLE;
        end else begin
          pcnt_nxt = pcnt_r - tpaf_pkg::PULSE_W'(1);
        end
      end
      default: begin
        state_nxt = tpaf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    gate_nxt = 1'b0;
    unique case (state_r)
      tpaf_pkg::ST_IDLE:  gate_nxt = 1'b0;
      tpaf_pkg::ST_WAIT:  gate_nxt = (dcnt_r == '0) && (cfg.pulse != '0);
      tpaf_pkg::ST_PULSE: gate_nxt = (pcnt_r != '0);
      default:            gate_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tpaf_pkg::ST_IDLE;
      dcnt_r      <= '0;
      pcnt_r      <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        state_r <= state_nxt;
        dcnt_r  <= dcnt_nxt;
        pcnt_r  <= pcnt_nxt;
        phase_r <= phase_nxt;
      end
      if (!t_stall) out_valid_r <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_gate_r  <= gate_nxt;
      out_busy_r  <= (state_nxt != tpaf_pkg::ST_IDLE);
      out_delay_r <= phase_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_gate_drive    = out_gate_r;
  assign out_busy_res      = out_busy_r;
  assign out_delay_setting = out_delay_r;

endmodule

// ===== rtl/core/triac_phase_angle_firing.sv =====
// ----------------------------------------------------------------------------
// triac_phase_angle_firing
// Phase-angle triac firing controller, one beat per microsecond tick.
// ----------------------------------------------------------------------------
// Every input beat is one tick and yields exactly one result beat. The block
// takes one tick per clock cycle while in_stall is low. Each tick passes four
// registers: the input register, the sample * half-cycle multiply, the divide
// by ADC full scale, and the sequencer that also loads the result. The divide
// stage folds with three dependent adds and one compare. Stages only hold when
// the result register is full and stalled, so bubbles in the pipe still soak
// up new ticks while a result waits. Configuration is written through
// cfg_we/cfg_addr/cfg_wdata; indexes past the register list are dropped and
// data is trimmed to the register width. No clearing pass after reset: all
// state is in flip-flops.
// ----------------------------------------------------------------------------
module triac_phase_angle_firing (
  input  logic                             clk,
  input  logic                             rst_n,
  // config write port
  input  logic                             cfg_we,
  input  logic [tpaf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [tpaf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // tick channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_zero_cross_rise,
  input  logic                             in_sample_valid,
  input  logic [tpaf_pkg::SAMPLE_W-1:0]    in_adc_sample,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_gate_drive,
  output logic                             out_busy_res,
  output logic [tpaf_pkg::HALF_W-1:0]      out_delay_setting
);

  tpaf_pkg::cfg_t   cfg_r;
  tpaf_pkg::tick_t  t_beat;
  logic             t_valid;
  logic             t_stall;

  // Config registers. To be written only while idle (the block does not enforce this), so no shadowing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_cycle <= tpaf_pkg::HALF_RST;
      cfg_r.pulse      <= tpaf_pkg::PULSE_RST;
      cfg_r.offset     <= tpaf_pkg::OFFS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tpaf_pkg::CFG_HALF_CYCLE: cfg_r.half_cycle <= cfg_wdata[tpaf_pkg::HALF_W-1:0];
        tpaf_pkg::CFG_PULSE:      cfg_r.pulse      <= cfg_wdata[tpaf_pkg::PULSE_W-1:0];
        tpaf_pkg::CFG_ZC_OFFSET:  cfg_r.offset     <= cfg_wdata[tpaf_pkg::OFFS_W-1:0];
        default: ;  // unmapped index, drop
      endcase
    end
  end

  // sample scaling pipe: delay = sample * half_cycle / full_scale
  tpaf_scale u_scale (
    .clk                (clk),
    .rst_n              (rst_n),
    .half_cycle         (cfg_r.half_cycle),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_zero_cross_rise (in_zero_cross_rise),
    .in_sample_valid    (in_sample_valid),
    .in_adc_sample      (in_adc_sample),
    .t_valid            (t_valid),
    .t_stall            (t_stall),
    .t_beat             (t_beat)
  );

  // firing sequencer and result register
  tpaf_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .t_valid           (t_valid),
    .t_stall           (t_stall),
    .t_beat            (t_beat),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_gate_drive    (out_gate_drive),
    .out_busy_res      (out_busy_res),
    .out_delay_setting (out_delay_setting)
  );

endmodule

// ===== rtl/core/tpaf_checker.sv =====
// ----------------------------------------------------------------------------
// tpaf_checker
// Port-level checks for the triac firing block, bound to the top level.
// ----------------------------------------------------------------------------
module tpaf_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_stall,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_gate_drive,
  input  logic                         out_busy_res,
  input  logic [tpaf_pkg::HALF_W-1:0]  out_delay_setting
);

  // gate is only fired inside a busy period
  a_gate_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gate_drive |-> out_busy_res)
    else $error("gate high while not busy");

  // input backpressure only comes from a stalled result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_gate_drive) && $stable(out_busy_res)
                               && $stable(out_delay_setting))
    else $error("stalled result payload changed");

endmodule

bind triac_phase_angle_firing tpaf_checker u_tpaf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_gate_drive    (out_gate_drive),
  .out_busy_res      (out_busy_res),
  .out_delay_setting (out_delay_setting)
);
